/* hdl/lsrm_pkg.sv */
// shared types and codes of the layer stack redraw manager
package lsrm_pkg;

  localparam logic [2:0] F_ALLOC   = 3'd0;
  localparam logic [2:0] F_SIZE    = 3'd1;
  localparam logic [2:0] F_HEIGHT  = 3'd2;
  localparam logic [2:0] F_REFRESH = 3'd3;
  localparam logic [2:0] F_SLIDE   = 3'd4;
  localparam logic [2:0] F_FREE    = 3'd5;

  localparam logic [1:0] CMD_ACK    = 2'd0;
  localparam logic [1:0] CMD_MAP    = 2'd1;
  localparam logic [1:0] CMD_REDRAW = 2'd2;

  localparam logic [3:0] CFG_SCR_W = 4'd0;
  localparam logic [3:0] CFG_SCR_H = 4'd1;

  localparam logic signed [8:0] HGT_NONE = -9'sd1;

  typedef struct packed {
    logic signed [11:0] ox;
    logic signed [11:0] oy;
    logic [10:0]        w;
    logic [10:0]        d;
  } geo_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic              rsel;
    logic [7:0]        hl;
    logic signed [8:0] hh;
  } plan_t;

  typedef struct packed {
    logic signed [13:0] ax;
    logic signed [13:0] ay;
    logic signed [13:0] bx;
    logic signed [13:0] by;
  } rect_t;

endpackage

/* hdl/lsrm_order_ram.sv */
// height-ordered table of layer ids, one read and one write port
module lsrm_order_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o,
  input  logic          we_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i
);
  logic [7:0] mem [Depth];
  logic [7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;
endmodule

/* hdl/lsrm_attr_ram.sv */
// per-layer height and geometry store, cleared by a pass over all entries after reset
module lsrm_attr_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  output logic                    clr_busy_o,
  input  logic                    rd_en_i,
  input  logic [AW-1:0]           rd_addr_i,
  output logic signed [8:0]       rd_hgt_o,
  output lsrm_pkg::geo_t          rd_geo_o,
  input  logic                    hwe_i,
  input  logic [AW-1:0]           haddr_i,
  input  logic signed [8:0]       hdata_i,
  input  logic                    gwe_i,
  input  logic [AW-1:0]           gaddr_i,
  input  lsrm_pkg::geo_t          gdata_i
);
  import lsrm_pkg::*;

  typedef struct packed {
    logic signed [8:0] h;
    geo_t              g;
  } attr_t;

  attr_t         mem [Depth];
  attr_t         rd_q;
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      // every entry starts hidden with zero geometry
      mem[clr_addr_q].h <= HGT_NONE;
      mem[clr_addr_q].g <= '0;
    end else begin
      if (hwe_i) begin
        mem[haddr_i].h <= hdata_i;
      end
      if (gwe_i) begin
        mem[gaddr_i].g <= gdata_i;
      end
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == AW'(Depth - 1)) clr_busy_q <= 1'b0;
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  assign clr_busy_o = clr_busy_q;
  assign rd_hgt_o   = rd_q.h;
  assign rd_geo_o   = rd_q.g;
endmodule

/* hdl/layer_stack_redraw_manager.sv */
// top level: command sequencer of the layer stack redraw manager
//
// channel  dir  handshake                       payload
// s_axis   in   s_axis_tvalid_i/s_axis_tready_o  tuser func, tdata layer..size_y
// m_axis   out  m_axis_tvalid_o/m_axis_tready_i  tuser cmd_kind, tdata rect..alloc_ok, tlast
// cfg      in   cfg_valid_i/cfg_ready_o          cfg_addr_i index, cfg_data_i value
//
// one command at a time: a decode step plus 1..4 results; alloc scans the
// use flags one id per cycle (up to MAX_LAYERS ids); a height change moves one order
// table entry per cycle through the order ram read/write ports.
// after reset a clearing pass over all MAX_LAYERS entries sets every layer hidden with zero
// geometry; the input side is held off until it ends.
// a stalled result holds the sequencer but the output register frees the input side.
module layer_stack_redraw_manager #(
  parameter int unsigned MAX_LAYERS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [2:0]  s_axis_tuser_i,   // func
  input  logic [87:0] s_axis_tdata_i,   // layer, level, pos_x, pos_y, end_x, end_y, size_x, size_y
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [1:0]  m_axis_tuser_o,   // cmd_kind
  output logic [79:0] m_axis_tdata_o,   // rect_x0, rect_y0, rect_x1, rect_y1, height_low,
                                        // height_high, alloc_id, alloc_ok
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_addr_i,
  input  logic [11:0] cfg_data_i
);
  import lsrm_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LAYERS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_ALLOC, ST_SHIFT, ST_FINAL, ST_EMIT
  } state_e;

  state_e             state_q;
  logic [2:0]         func_q;
  logic [7:0]         id_q;
  logic signed [8:0]  lvl_q;
  logic signed [11:0] px_q, py_q, ex_q, ey_q;
  logic [10:0]        sx_q, sy_q;
  logic               ok_q;
  logic signed [8:0]  top_q;
  logic [MAX_LAYERS-1:0] use_q;
  logic [AW-1:0]      scan_q, j_q, pdst_q, hnew_q;
  logic [AW:0]        cnt_q;
  logic               up_q, pend_q, wid_q;
  plan_t              plan_q [4];
  rect_t              rect_q [2];
  logic [1:0]         ln_q, e_q;
  logic [7:0]         aid_q;
  logic               aok_q;
  logic [11:0]        scr_w_q, scr_h_q;
  logic               m_valid_q;
  logic [1:0]         m_kind_q;
  logic [79:0]        m_data_q;
  logic               m_last_q;

  logic               s_acc, s_ok;
  logic [7:0]         s_layer;
  logic signed [8:0]  a_hgt;
  geo_t               a_geo;
  logic [7:0]         o_rd;
  logic               a_clr;

  // ram controls
  logic               o_re, o_we, a_hwe, a_gwe;
  logic [AW-1:0]      o_raddr, o_waddr, a_haddr;
  logic [7:0]         o_wdata;
  logic signed [8:0]  a_hdata;
  geo_t               a_gdata;

  logic signed [9:0]  old_h, top_e, lvl_e, lim, hc;
  logic               do_sh, alloc_hit, out_load;
  logic [AW-1:0]      sh_src;
  rect_t              r_layer, r_ref, r_new;
  plan_t              cur_p;
  rect_t              cur_r;

  function automatic plan_t mk(logic [1:0] kind, logic rsel, logic signed [9:0] hl,
                               logic signed [9:0] hh);
    plan_t p;
    p.kind = kind;
    p.rsel = rsel;
    p.hl   = hl[7:0];
    p.hh   = hh[8:0];
    return p;
  endfunction

  function automatic logic [11:0] clip_lo(logic signed [13:0] v);
    return (v < 0) ? 12'd0 : v[11:0];
  endfunction

  function automatic logic [12:0] clip_hi(logic signed [13:0] v, logic [11:0] lim_v);
    return (v > $signed({2'b00, lim_v})) ? {1'b0, lim_v} : v[12:0];
  endfunction

  assign s_axis_tready_o = (state_q == ST_IDLE) && !a_clr;
  assign s_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign s_layer = s_axis_tdata_i[7:0];
  assign s_ok    = ({1'b0, s_layer} < 9'(MAX_LAYERS)) && use_q[s_layer[AW-1:0]];
  assign cfg_ready_o = 1'b1;

  // height clamp of the set-height path, free uses a hide request
  always_comb begin
    old_h = 10'(a_hgt);
    top_e = 10'(top_q);
    lvl_e = (func_q == F_FREE) ? -10'sd1 : 10'(lvl_q);
    lim   = (old_h >= 0) ? top_e : top_e + 10'sd1;
    hc    = (lvl_e > lim) ? lim : lvl_e;
    if (hc < -10'sd1) hc = -10'sd1;
  end

  assign do_sh = (state_q == ST_DECODE) && ok_q && (hc != old_h) &&
                 ((func_q == F_HEIGHT) || ((func_q == F_FREE) && (old_h >= 0)));
  assign alloc_hit = (state_q == ST_ALLOC) && !use_q[scan_q];
  assign sh_src = up_q ? j_q + AW'(1) : j_q - AW'(1);
  assign out_load = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready_i);

  always_comb begin
    r_layer.ax = 14'(a_geo.ox);
    r_layer.ay = 14'(a_geo.oy);
    r_layer.bx = 14'(a_geo.ox) + $signed({3'b000, a_geo.w});
    r_layer.by = 14'(a_geo.oy) + $signed({3'b000, a_geo.d});
    r_ref.ax   = 14'(a_geo.ox) + 14'(px_q);
    r_ref.ay   = 14'(a_geo.oy) + 14'(py_q);
    r_ref.bx   = 14'(a_geo.ox) + 14'(ex_q);
    r_ref.by   = 14'(a_geo.oy) + 14'(ey_q);
    r_new.ax   = 14'(px_q);
    r_new.ay   = 14'(py_q);
    r_new.bx   = 14'(px_q) + $signed({3'b000, a_geo.w});
    r_new.by   = 14'(py_q) + $signed({3'b000, a_geo.d});
  end

  always_comb begin
    o_re    = (state_q == ST_SHIFT) && (cnt_q != '0);
    o_raddr = sh_src;
    o_we    = 1'b0;
    o_waddr = pdst_q;
    o_wdata = o_rd;
    if ((state_q == ST_SHIFT) && pend_q) begin
      o_we = 1'b1;
    end else if ((state_q == ST_FINAL) && wid_q) begin
      o_we    = 1'b1;
      o_waddr = hnew_q;
      o_wdata = id_q;
    end

    a_hwe   = 1'b0;
    a_haddr = id_q[AW-1:0];
    a_hdata = hc[8:0];
    if (do_sh) begin
      a_hwe = 1'b1;
    end else if (alloc_hit) begin
      a_hwe   = 1'b1;
      a_haddr = scan_q;
      a_hdata = HGT_NONE;
    end else if ((state_q == ST_SHIFT) && pend_q) begin
      // moved layer takes the height of its new slot
      a_hwe   = 1'b1;
      a_haddr = o_rd[AW-1:0];
      a_hdata = 9'(pdst_q);
    end

    a_gwe   = (state_q == ST_DECODE) && ok_q && ((func_q == F_SIZE) || (func_q == F_SLIDE));
    a_gdata = a_geo;
    if (func_q == F_SIZE) begin
      a_gdata.w = sx_q;
      a_gdata.d = sy_q;
    end else begin
      a_gdata.ox = px_q;
      a_gdata.oy = py_q;
    end
  end

  assign cur_p = plan_q[e_q];
  assign cur_r = rect_q[cur_p.rsel];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      top_q     <= HGT_NONE;
      use_q     <= '0;
      scr_w_q   <= 12'd320;
      scr_h_q   <= 12'd200;
      m_valid_q <= 1'b0;
      pend_q    <= 1'b0;
      cnt_q     <= '0;
      e_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_addr_i)
          CFG_SCR_W: scr_w_q <= cfg_data_i;
          CFG_SCR_H: scr_h_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (m_valid_q && m_axis_tready_i) m_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            func_q  <= s_axis_tuser_i;
            id_q    <= s_layer;
            lvl_q   <= s_axis_tdata_i[16:8];
            px_q    <= s_axis_tdata_i[28:17];
            py_q    <= s_axis_tdata_i[40:29];
            ex_q    <= s_axis_tdata_i[52:41];
            ey_q    <= s_axis_tdata_i[64:53];
            sx_q    <= s_axis_tdata_i[75:65];
            sy_q    <= s_axis_tdata_i[86:76];
            ok_q    <= s_ok;
            state_q <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          aid_q      <= '0;
          aok_q      <= 1'b0;
          plan_q[0]  <= mk(CMD_ACK, 1'b0, '0, '0);
          ln_q       <= 2'd0;
          e_q        <= 2'd0;
          rect_q[0]  <= (func_q == F_REFRESH) ? r_ref : r_layer;
          rect_q[1]  <= r_new;
          state_q    <= ST_EMIT;
          if (func_q == F_ALLOC) begin
            scan_q  <= '0;
            state_q <= ST_ALLOC;
          end else if (ok_q) begin
            if (func_q == F_FREE) use_q[id_q[AW-1:0]] <= 1'b0;
            if (do_sh) begin
              state_q <= ST_SHIFT;
              hnew_q  <= hc[AW-1:0];
              ln_q    <= 2'd1;
              if (hc < old_h && hc >= 0) begin
                j_q <= old_h[AW-1:0]; cnt_q <= (AW+1)'(old_h - hc); up_q <= 1'b0;
                wid_q <= 1'b1;
                plan_q[0] <= mk(CMD_MAP, 1'b0, hc + 10'sd1, top_e);
                plan_q[1] <= mk(CMD_REDRAW, 1'b0, hc + 10'sd1, old_h);
              end else if (hc < old_h) begin
                // hide: entries above close the gap
                j_q <= old_h[AW-1:0]; cnt_q <= (AW+1)'(top_e - old_h); up_q <= 1'b1;
                wid_q <= 1'b0;
                top_q <= top_q - 9'sd1;
                plan_q[0] <= mk(CMD_MAP, 1'b0, '0, top_e - 10'sd1);
                plan_q[1] <= mk(CMD_REDRAW, 1'b0, '0, old_h - 10'sd1);
              end else if (old_h >= 0) begin
                j_q <= old_h[AW-1:0]; cnt_q <= (AW+1)'(hc - old_h); up_q <= 1'b1;
                wid_q <= 1'b1;
                plan_q[0] <= mk(CMD_MAP, 1'b0, hc, top_e);
                plan_q[1] <= mk(CMD_REDRAW, 1'b0, hc, hc);
              end else begin
                // show: entries from the new height up move one slot up
                j_q <= AW'(top_e + 10'sd1); cnt_q <= (AW+1)'(top_e + 10'sd1 - hc);
                up_q <= 1'b0; wid_q <= 1'b1;
                top_q <= top_q + 9'sd1;
                plan_q[0] <= mk(CMD_MAP, 1'b0, hc, top_e + 10'sd1);
                plan_q[1] <= mk(CMD_REDRAW, 1'b0, hc, hc);
              end
            end else if ((func_q == F_REFRESH) && (old_h >= 0)) begin
              plan_q[0] <= mk(CMD_REDRAW, 1'b0, old_h, old_h);
            end else if ((func_q == F_SLIDE) && (old_h >= 0)) begin
              plan_q[0] <= mk(CMD_MAP, 1'b0, '0, top_e);
              plan_q[1] <= mk(CMD_MAP, 1'b1, old_h, top_e);
              plan_q[2] <= mk(CMD_REDRAW, 1'b0, '0, old_h - 10'sd1);
              plan_q[3] <= mk(CMD_REDRAW, 1'b1, old_h, old_h);
              ln_q      <= 2'd3;
            end
          end
        end
        ST_ALLOC: begin
          if (alloc_hit) begin
            use_q[scan_q] <= 1'b1;
            aid_q   <= 8'(scan_q);
            aok_q   <= 1'b1;
            state_q <= ST_EMIT;
          end else if (scan_q == AW'(MAX_LAYERS - 1)) begin
            state_q <= ST_EMIT;
          end else begin
            scan_q <= scan_q + AW'(1);
          end
        end
        ST_SHIFT: begin
          pend_q <= (cnt_q != '0);
          pdst_q <= j_q;
          if (cnt_q != '0) begin
            cnt_q <= cnt_q - (AW+1)'(1);
            j_q   <= sh_src;
          end else if (!pend_q) begin
            state_q <= ST_FINAL;
          end
        end
        ST_FINAL: state_q <= ST_EMIT;
        ST_EMIT: begin
          if (out_load) begin
            m_valid_q <= 1'b1;
            m_kind_q  <= cur_p.kind;
            m_last_q  <= (e_q == ln_q);
            if (cur_p.kind == CMD_ACK) begin
              m_data_q <= {4'd0, aok_q, aid_q, 67'd0};
            end else begin
              m_data_q <= {4'd0, 1'b0, 8'd0, cur_p.hh, cur_p.hl,
                           clip_hi(cur_r.by, scr_h_q), clip_hi(cur_r.bx, scr_w_q),
                           clip_lo(cur_r.ay), clip_lo(cur_r.ax)};
            end
            if (e_q == ln_q) state_q <= ST_IDLE;
            else e_q <= e_q + 2'd1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_kind_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  lsrm_order_ram #(.Depth(MAX_LAYERS), .AW(AW)) u_order (
    .clk_i     (clk_i),
    .rd_en_i   (o_re),
    .rd_addr_i (o_raddr),
    .rd_data_o (o_rd),
    .we_i      (o_we),
    .wr_addr_i (o_waddr),
    .wr_data_i (o_wdata)
  );

  lsrm_attr_ram #(.Depth(MAX_LAYERS), .AW(AW)) u_attr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_busy_o (a_clr),
    .rd_en_i    (s_acc),
    .rd_addr_i  (s_layer[AW-1:0]),
    .rd_hgt_o   (a_hgt),
    .rd_geo_o   (a_geo),
    .hwe_i      (a_hwe),
    .haddr_i    (a_haddr),
    .hdata_i    (a_hdata),
    .gwe_i      (a_gwe),
    .gaddr_i    (id_q[AW-1:0]),
    .gdata_i    (a_gdata)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o) else $error("input taken while busy");
  a_out_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_valid_q || m_axis_tready_i)) else $error("result overwritten");
  a_shift_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINAL) |-> (!pend_q && cnt_q == '0)) else $error("shift not drained");
  a_top_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $signed(10'(top_q)) < $signed(10'(MAX_LAYERS))) else $error("top index out of range");
endmodule
